// ===== rtl/core/disk_request_to_chs_command_top_defines.svh =====
// Assertion macros for the disk request to CHS command block.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef DISK_REQUEST_TO_CHS_COMMAND_TOP_DEFINES_SVH
`define DISK_REQUEST_TO_CHS_COMMAND_TOP_DEFINES_SVH
`ifndef SYNTH
`define DRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DRC_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DRC_ASSERT(lbl, clk, rstn, prop, msg)
`define DRC_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/drc_pkg.sv =====
// Shared types and constants for the disk request to CHS command block.
// Used by the controller, the datapath and the top level.
package drc_pkg;

  // Fields of one input item.
  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         device;
    logic signed [31:0] position;
    logic [15:0]        byte_count;
    logic [30:0]        entry_base;
    logic [30:0]        entry_length;
    logic [4:0]         entry_heads;
    logic [7:0]         entry_sectors;
    logic [7:0]         entry_control;
    logic [7:0]         entry_precomp;
  } drc_in_t;

  // Fields of one result item.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] control_byte;
    logic [7:0] precomp_byte;
    logic [7:0] sector_count;
    logic [7:0] sector_number;
    logic [7:0] cylinder_low;
    logic [7:0] cylinder_high;
    logic [7:0] drive_head;
    logic [7:0] command_code;
  } drc_out_t;

  // Command codes.
  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  // Status codes.
  localparam logic [2:0] StIssued = 3'd0;
  localparam logic [2:0] StIoErr  = 3'd1;
  localparam logic [2:0] StInval  = 3'd2;
  localparam logic [2:0] StBeyond = 3'd3;
  localparam logic [2:0] StLoaded = 3'd4;

  localparam logic [7:0] DriveHeadBase = 8'hA0;
  localparam logic [7:0] AtaRead       = 8'h20;
  localparam logic [7:0] AtaWrite      = 8'h30;
  localparam int unsigned SectorBytes  = 512;

  // Division width: the absolute sector fits in 32 bits.
  localparam int unsigned DivW = 32;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;   // take the input item
    logic check;     // evaluate request checks
    logic div_start; // start the division
    logic div_step;  // one restoring step
    logic finish;    // form the result
  } drc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_load;
    logic early_done;  // result known without division
    logic div_last;    // final step of the division
  } drc_stat_t;

endpackage

// ===== rtl/core/drc_ctrl.sv =====
// Controller state machine for the disk request to CHS command block.
// Depends on drc_pkg and the assertion macros header.
`include "disk_request_to_chs_command_top_defines.svh"
module drc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output drc_pkg::drc_cmd_t cmd_o,
  input  drc_pkg::drc_stat_t stat_i
);
  import drc_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SDiv1  = 3'd2;
  localparam logic [2:0] SDiv2  = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       busy_take;
  logic       out_take;

  assign out_take  = out_valid_o && !out_stall_i;
  assign busy_take = in_valid_i && !in_stall_o;
  // Input is free when idle, or when the waiting result leaves this cycle.
  assign in_stall_o  = !(state_q == SIdle || (state_q == SOut && out_take));
  assign out_valid_o = (state_q == SOut);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.capture = busy_take;
    case (state_q)
      SIdle: begin
        if (busy_take) state_d = SCheck;
      end
      SCheck: begin
        cmd_o.check = 1'b1;
        if (stat_i.early_done) begin
          cmd_o.finish = 1'b1;
          state_d = SOut;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = SDiv1;
        end
      end
      SDiv1: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          cmd_o.div_start = 1'b1;
          state_d = SDiv2;
        end
      end
      SDiv2: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = SDone;
      end
      SDone: begin
        cmd_o.finish = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        if (out_take) state_d = busy_take ? SCheck : SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `DRC_ASSERT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `DRC_ASSERT(a_no_take_busy, clk_i, rst_ni, (state_q == SDiv1 || state_q == SDiv2) |-> in_stall_o, "item taken during division")
  `DRC_ASSERT(a_check_follows, clk_i, rst_ni, busy_take |=> state_q == SCheck, "accepted item not checked")
endmodule

// ===== rtl/core/drc_dpath.sv =====
// Datapath: entry table, request checks, shared restoring divider, result.
// Depends on drc_pkg.
module drc_dpath #(
  parameter int unsigned BlockBytes = 1024,
  parameter int unsigned Drives     = 2,
  parameter int unsigned Partitions = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drc_pkg::drc_in_t   in_i,
  input  logic [1:0]         drive_count_i,
  input  drc_pkg::drc_cmd_t  cmd_i,
  output drc_pkg::drc_stat_t stat_o,
  output drc_pkg::drc_out_t  out_o
);
  import drc_pkg::*;

  localparam int unsigned PerDrive  = Partitions + 1;
  localparam int unsigned Entries   = Drives * PerDrive;
  localparam int unsigned BlkShift  = $clog2(BlockBytes);
  localparam int unsigned SecPerBlk = BlockBytes / SectorBytes;
  localparam int unsigned CntW      = $clog2(DivW + 1);

  // Entry table; reset clears every entry to zero.
  logic [30:0] base_q   [Entries];
  logic [30:0] length_q [Entries];
  logic [4:0]  heads_q  [Entries];
  logic [7:0]  spt_q    [Entries];
  logic [7:0]  ctrl_q   [Entries];
  logic [7:0]  pre_q    [Entries];

  drc_in_t     item_q;
  logic [1:0]  drive_q;
  logic [7:0]  spt_sel_q;

  // Divider registers.
  logic [DivW-1:0] quo_q, rem_q, dvd_d;
  logic [12:0]     dvs_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] cyl_q;
  logic            pass_q;
  drc_out_t        res_q;

  logic            dev_ok;
  logic [3:0]      dev_idx;
  logic [1:0]      drive_w;
  logic [2:0]      chk_status;
  logic            chk_go;
  logic [41:0]     limit_w;
  logic [DivW-1:0] sector_w;
  logic [DivW:0]   trial;
  logic [DivW-1:0] rem_sh;

  assign dev_idx = item_q.device;
  assign dev_ok  = 32'(dev_idx) < Entries;
  // At most two drives, so the drive is set by one compare against the entries per drive.
  assign drive_w = (32'(dev_idx) >= PerDrive) ? 2'd1 : 2'd0;
  assign limit_w = ({11'b0, length_q[dev_ok ? dev_idx : 4'd0]} << 9) - 42'(BlockBytes);
  assign sector_w = 32'(item_q.position[31:9]) + 32'(base_q[dev_ok ? dev_idx : 4'd0]);

  // Request checks in order.
  always_comb begin
    chk_status = StIssued;
    chk_go     = 1'b0;
    if (item_q.cmd == CmdLoad) begin
      chk_status = dev_ok ? StLoaded : StInval;
    end else if (!(item_q.cmd == CmdRead || item_q.cmd == CmdWrite)) begin
      chk_status = StInval;
    end else if (!dev_ok) begin
      chk_status = StIoErr;
    end else if (32'(item_q.byte_count) != BlockBytes) begin
      chk_status = StInval;
    end else if (drive_w >= drive_count_i) begin
      chk_status = StIoErr;
    end else if (item_q.position[BlkShift-1:0] != '0) begin
      chk_status = StInval;
    end else if (item_q.position[31] ||
                 $signed({10'b0, item_q.position}) > $signed(limit_w)) begin
      chk_status = StBeyond;
    end else if (heads_q[dev_idx] == '0 || spt_q[dev_idx] == '0) begin
      chk_status = StIoErr;
    end else begin
      chk_go = 1'b1;
    end
  end

  assign stat_o.is_load    = (item_q.cmd == CmdLoad);
  assign stat_o.early_done = !chk_go;
  assign stat_o.div_last   = (cnt_q == CntW'(1));

  // One restoring division step.
  assign rem_sh = {rem_q[DivW-2:0], quo_q[DivW-1]};
  assign trial  = {1'b0, rem_sh} - {20'b0, dvs_q};
  assign dvd_d  = pass_q ? rem_q : sector_w;

  // Table writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        base_q[i] <= '0; length_q[i] <= '0; heads_q[i] <= '0;
        spt_q[i] <= '0; ctrl_q[i] <= '0; pre_q[i] <= '0;
      end
    end else if (cmd_i.check && item_q.cmd == CmdLoad && dev_ok) begin
      base_q[dev_idx]   <= item_q.entry_base;
      length_q[dev_idx] <= item_q.entry_length;
      heads_q[dev_idx]  <= item_q.entry_heads;
      spt_q[dev_idx]    <= item_q.entry_sectors;
      ctrl_q[dev_idx]   <= item_q.entry_control;
      pre_q[dev_idx]    <= item_q.entry_precomp;
    end
  end

  // Item capture, divider and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_i;
    if (cmd_i.check) begin
      drive_q    <= drive_w;
      spt_sel_q  <= spt_q[dev_ok ? dev_idx : 4'd0];
      pass_q     <= 1'b0;
    end
    // First pass: sector / (heads * sectors per track); second: remainder / sectors per track.
    if (cmd_i.div_start) begin
      quo_q <= cmd_i.check ? sector_w : dvd_d;
      rem_q <= '0;
      dvs_q <= cmd_i.check ? 13'(heads_q[dev_idx] * spt_q[dev_idx]) : {5'b0, spt_sel_q};
      cnt_q <= CntW'(DivW);
      if (!cmd_i.check) begin
        pass_q <= 1'b1;
        cyl_q  <= {quo_q[DivW-2:0], !trial[DivW]};
      end
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DivW-2:0], !trial[DivW]};
      rem_q <= trial[DivW] ? rem_sh : trial[DivW-1:0];
      cnt_q <= cnt_q - CntW'(1);
    end
    if (cmd_i.div_start && !cmd_i.check) begin
      quo_q <= trial[DivW] ? rem_sh : trial[DivW-1:0];
    end
    if (cmd_i.finish) begin
      res_q <= '0;
      if (cmd_i.check) begin
        res_q.status <= chk_status;
      end else begin
        res_q.status        <= StIssued;
        res_q.control_byte  <= ctrl_q[dev_idx];
        res_q.precomp_byte  <= pre_q[dev_idx];
        res_q.sector_count  <= 8'(SecPerBlk);
        res_q.sector_number <= 8'(rem_q) + 8'd1;
        res_q.cylinder_low  <= cyl_q[7:0];
        res_q.cylinder_high <= cyl_q[15:8];
        res_q.drive_head    <= DriveHeadBase | 8'({drive_q, 4'b0}) | 8'(quo_q);
        res_q.command_code  <= (item_q.cmd == CmdRead) ? AtaRead : AtaWrite;
      end
    end
  end

  assign out_o = res_q;
endmodule

// ===== rtl/core/disk_request_to_chs_command_top.sv =====
// Top level of the disk request to CHS command block.
// Depends on drc_pkg, drc_ctrl and drc_dpath.
//
//  channel | handshake            | payload
//  in      | in_valid_i/in_stall_o | in_item_i  (drc_in_t)
//  out     | out_valid_o/out_stall_i | out_item_o (drc_out_t)
//  cfg     | cfg_we_i             | cfg_data_i (drive_count)
//
// A load or a rejected request goes from the check state straight to the result.
// An issued request makes two 32-step passes of one restoring divider
// (cylinder by sectors per cylinder, then head and sector by sectors/track).
// Reset clears the entry table and drive count at once; no clearing pass.
// A waiting result holds under stall; the next item is taken as it leaves.
module disk_request_to_chs_command_top #(
  parameter int unsigned BlockBytes = 1024,
  parameter int unsigned Drives     = 2,
  parameter int unsigned Partitions = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  drc_pkg::drc_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output drc_pkg::drc_out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_data_i
);
  import drc_pkg::*;

  drc_cmd_t   cmd;
  drc_stat_t  stat;
  logic [1:0] drive_count_q;

  // Drive count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_count_q <= '0;
    end else if (cfg_we_i) begin
      drive_count_q <= cfg_data_i;
    end
  end

  drc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  drc_dpath #(.BlockBytes(BlockBytes), .Drives(Drives), .Partitions(Partitions)) u_dpath (
    .clk_i, .rst_ni, .in_i(in_item_i), .drive_count_i(drive_count_q),
    .cmd_i(cmd), .stat_o(stat), .out_o(out_item_o)
  );
endmodule
